// File: rtl/bounded_integer_set_assert.svh
// ----------------------------------------------------------------------------
// bounded_integer_set assertion macros
// clocked, reset-qualified assertion helpers for the set checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_ASSERT_SVH
`define BOUNDED_INTEGER_SET_ASSERT_SVH

// property must hold at every clock edge out of reset
`define BIS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define BIS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `BIS_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// File: rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// types and codes shared by the bounded integer set and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int COUNT_W      = 8;
    localparam int VALUE_W      = 32;

    // request kinds; the unused code behaves as a query
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_PRESENT     = 3'd1,
        ST_FULL        = 3'd2,
        ST_REMOVED     = 3'd3,
        ST_NOT_PRESENT = 3'd4,
        ST_FOUND       = 3'd5,
        ST_ABSENT      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/bounded_integer_set.sv
// ----------------------------------------------------------------------------
// bounded_integer_set
// fixed-capacity set of 32-bit integers searched one entry per cycle
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid / req_stall / req): one word carries a kind
//   (insert, remove, query; the spare code acts as a query) and a value.
//   response channel (rsp_valid / rsp_stall / rsp): exactly one word per
//   request with a status code and the element count after the request.
// timing
//   the block takes one request at a time and holds req_stall high while it
//   works. the search walks the occupied entries through the single read
//   port of the entry memory, one compare per cycle, pipelined behind the
//   registered read data; it ends at the match, or after all held entries
//   on a miss. a remove that hits then fetches the last entry and writes it
//   into the freed slot. a refused insert on a full set skips the search.
//   a new request is taken only once the last response has been loaded and
//   the block is back in its idle state.
// reset and stalls
//   reset empties the set at once (count to zero); memory contents are not
//   cleared since only entries below the count are ever read. a stalled
//   response holds; a finished request waits for the response register to
//   drain and no new request is taken until it has moved in.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_integer_set #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bis_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bis_pkg::rsp_t      rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry storage, one write and one registered read port
    logic [bis_pkg::VALUE_W-1:0] mem [0:CAPACITY-1];
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    logic [bis_pkg::VALUE_W-1:0] mem_wdata;
    logic [IDX_W-1:0]            mem_raddr;
    logic [bis_pkg::VALUE_W-1:0] rdata_reg;

    // sequencer state
    bis_pkg::state_t             state_reg,    state_next;
    logic [CNT_W-1:0]            count_reg,    count_next;
    logic [CNT_W-1:0]            idx_reg,      idx_next;
    logic                        pend_reg,     pend_next;
    logic [IDX_W-1:0]            pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]            slot_reg,     slot_next;
    logic [1:0]                  kind_reg,     kind_next;
    logic [bis_pkg::VALUE_W-1:0] value_reg,    value_next;
    bis_pkg::status_t            status_reg,   status_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    bis_pkg::rsp_t               rsp_reg,      rsp_next;

    logic                        hit;
    logic                        scan_more;
    logic [CNT_W-1:0]            count_m1;
    logic [CNT_W+7:0]            count_ext;

    assign req_stall = (state_reg != bis_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // compare stage sees the word read in the previous cycle
    assign hit       = pend_reg && (rdata_reg == value_reg);
    assign scan_more = (idx_reg < count_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_ext = {8'd0, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        slot_next      = slot_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_wdata      = value_reg;
        mem_raddr      = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            bis_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    value_next = req.value;
                    idx_next   = '0;
                    if ((req.kind == bis_pkg::KIND_INSERT) &&
                        (count_reg >= CNT_W'(CAPACITY)))
                    begin
                        // full check comes before the search
                        status_next = bis_pkg::ST_FULL;
                        state_next  = bis_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = bis_pkg::S_SCAN;
                    end
                end
            end

            bis_pkg::S_SCAN:
            begin
                // issue the next read while comparing the previous one
                if (scan_more)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                priority if (hit)
                begin
                    slot_next = pend_idx_reg;
                    priority if (kind_reg == bis_pkg::KIND_INSERT)
                    begin
                        status_next = bis_pkg::ST_PRESENT;
                        state_next  = bis_pkg::S_DONE;
                    end
                    else if (kind_reg == bis_pkg::KIND_REMOVE)
                    begin
                        state_next = bis_pkg::S_FETCH;
                    end
                    else
                    begin
                        status_next = bis_pkg::ST_FOUND;
                        state_next  = bis_pkg::S_DONE;
                    end
                end
                else if (!pend_reg && !scan_more)
                begin
                    // search exhausted
                    priority if (kind_reg == bis_pkg::KIND_INSERT)
                    begin
                        mem_we      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = bis_pkg::ST_ADDED;
                    end
                    else if (kind_reg == bis_pkg::KIND_REMOVE)
                    begin
                        status_next = bis_pkg::ST_NOT_PRESENT;
                    end
                    else
                    begin
                        status_next = bis_pkg::ST_ABSENT;
                    end
                    state_next = bis_pkg::S_DONE;
                end
                else
                begin
                    state_next = bis_pkg::S_SCAN;
                end
            end

            bis_pkg::S_FETCH:
            begin
                // read the last held entry
                mem_raddr  = count_m1[IDX_W-1:0];
                state_next = bis_pkg::S_MOVE;
            end

            bis_pkg::S_MOVE:
            begin
                // last entry fills the freed slot
                mem_we      = 1'b1;
                mem_waddr   = slot_reg;
                mem_wdata   = rdata_reg;
                count_next  = count_m1;
                status_next = bis_pkg::ST_REMOVED;
                state_next  = bis_pkg::S_DONE;
            end

            bis_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next.status = status_reg;
                    rsp_next.count  = count_ext[7:0];
                    state_next      = bis_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bis_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bis_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// port-level checks on the bounded integer set
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_integer_set_assert.svh"

module bis_checker #(
    parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire bis_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire bis_pkg::rsp_t rsp
);

    logic [7:0] cap_word;

    assign cap_word = 8'(CAPACITY);

    // a stalled response word holds
    `BIS_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response word changed while stalled")

    // one request at a time: busy right after an accept
    `BIS_ASSERT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall |=> req_stall, "request taken while previous one in flight")

    // a refused insert only happens with the set at capacity
    `BIS_ASSERT_NEVER(a_full_count, clk, rst_n, rsp_valid && (rsp.status == bis_pkg::ST_FULL) && (rsp.count != cap_word), "full status with count below capacity")

    // count never passes capacity
    `BIS_ASSERT_NEVER(a_count_bound, clk, rst_n, rsp_valid && (CAPACITY < 256) && (rsp.count > cap_word), "count above capacity")

endmodule

bind bounded_integer_set bis_checker #(
    .CAPACITY (CAPACITY)
) u_bis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
